### src/assert_macros.svh
// Assertion macros shared by the executor RTL.
// Defining ASSERT_OFF leaves every use empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define SCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define SCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/sce_pkg.sv
// Types and constants of the stack CPU instruction executor.
// No dependencies.
`default_nettype none
package sce_pkg;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 240;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_WS = 1'b1;

    localparam logic [1:0] KIND_EXEC    = 2'd0;
    localparam logic [1:0] KIND_WRB     = 2'd1;
    localparam logic [1:0] KIND_RDB     = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [3:0] OP_J     = 4'h0;
    localparam logic [3:0] OP_LDLP  = 4'h1;
    localparam logic [3:0] OP_PFIX  = 4'h2;
    localparam logic [3:0] OP_LDNL  = 4'h3;
    localparam logic [3:0] OP_LDC   = 4'h4;
    localparam logic [3:0] OP_LDNLP = 4'h5;
    localparam logic [3:0] OP_NFIX  = 4'h6;
    localparam logic [3:0] OP_LDL   = 4'h7;
    localparam logic [3:0] OP_AJW   = 4'hB;
    localparam logic [3:0] OP_EQC   = 4'hC;
    localparam logic [3:0] OP_STL   = 4'hD;
    localparam logic [3:0] OP_STNL  = 4'hE;
    localparam logic [3:0] OP_OPR   = 4'hF;

    localparam logic [31:0] OPR_REV  = 32'h00;
    localparam logic [31:0] OPR_ADD  = 32'h05;
    localparam logic [31:0] OPR_SUB  = 32'h0C;
    localparam logic [31:0] OPR_STHF = 32'h18;
    localparam logic [31:0] OPR_LDPI = 32'h1B;
    localparam logic [31:0] OPR_STLF = 32'h1C;
    localparam logic [31:0] OPR_BCNT = 32'h34;
    localparam logic [31:0] OPR_GAJW = 32'h3C;
    localparam logic [31:0] OPR_WCNT = 32'h3F;
    localparam logic [31:0] OPR_MINT = 32'h42;
    localparam logic [31:0] OPR_MOVE = 32'h4A;

    localparam logic [31:0] MINT_VALUE = 32'h8000_0000;
    localparam logic [31:0] WORD_ALIGN = ~32'd3;
    localparam logic [31:0] BYTE_SEL   = 32'd3;
    localparam logic [31:0] NIB_MASK   = 32'hF;

    typedef enum logic [2:0] {
        CLS_ALU,
        CLS_LOAD,
        CLS_STORE,
        CLS_MOVE,
        CLS_WRB,
        CLS_RDB,
        CLS_RESTART
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic        illegal;
        logic [3:0]  opcode;
        logic [31:0] operand;
        logic [11:0] mem_addr;
        logic [7:0]  mem_byte;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STORE,
        ST_RDB,
        ST_SNAP,
        ST_DIV,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;
endpackage
`default_nettype wire

### src/stack_cpu_instruction_executor.sv
// Top level of the stack CPU instruction executor: front end, item queue, back end.
// Depends on sce_pkg, sce_front, sce_queue and sce_back.
//
//   channel  | ports                         | content
//   input    | s_tvalid s_tready s_tdata     | tdata: instr_byte, mem_addr, mem_byte; tuser: kind
//   result   | m_tvalid m_tready m_tdata     | stack, pc, workspace, flags, read byte, pointers
//   config   | cfg_we cfg_addr cfg_wdata     | 0 start_pc, 1 start_workspace
//
// Register ops, byte write and restart finish in ST_IDLE; byte read passes ST_RDB; word load
// and word store pass ST_LOAD and ST_STORE, one byte at a time through the byte memory.
// move: dispatch, a snapshot sweep of memory into snap, a remainder step in ST_DIV when the
// count exceeds MEM_BYTES, then ST_COPY_RD and ST_COPY_WR per byte copied (at most MEM_BYTES).
// Reset is synchronous; memory contents are not cleared. MEM_BYTES must be a power of two;
// unchecked. The 2-entry queue takes input until full while a result waits for m_tready.
`default_nettype none
module stack_cpu_instruction_executor #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [sce_pkg::IN_TDATA_W-1:0]      s_tdata,  // instr_byte, mem_addr, mem_byte
    input  wire logic [1:0]                          s_tuser,  // kind
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // reg_a, reg_b, reg_c, next_pc, workspace, overflow_flag, illegal, read_byte,
    // fptr_front, fptr_back
    output logic [sce_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [31:0]                         cfg_wdata
);
    sce_pkg::item_t push_item, pop_item;
    logic q_push, q_full, q_pop, q_valid;

    sce_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    sce_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .item_in  (push_item),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (pop_item)
    );

    sce_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire

### src/sce_front.sv
// Front end: accepts input transfers, tracks the prefix operand and classifies items.
// Depends on sce_pkg.
`default_nettype none
module sce_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [sce_pkg::IN_TDATA_W-1:0]     s_tdata,  // instr_byte, mem_addr, mem_byte
    input  wire logic [1:0]                         s_tuser,  // kind
    input  wire logic                               q_full,
    output logic                                    q_push,
    output sce_pkg::item_t                          q_item
);
    logic [31:0] operand_reg, operand_next;
    logic [7:0]  ib;
    logic [31:0] n;

    assign ib       = s_tdata[7:0];
    assign n        = operand_reg | ({24'b0, ib} & sce_pkg::NIB_MASK);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.cls      = sce_pkg::CLS_ALU;
        q_item.illegal  = 1'b0;
        q_item.opcode   = ib[7:4];
        q_item.operand  = n;
        q_item.mem_addr = s_tdata[19:8];
        q_item.mem_byte = s_tdata[27:20];
        operand_next    = operand_reg;
        unique case (s_tuser)
            sce_pkg::KIND_EXEC: begin
                operand_next = '0;
                unique case (ib[7:4])
                    sce_pkg::OP_PFIX: operand_next = n << 4;
                    sce_pkg::OP_NFIX: operand_next = (~n) << 4;
                    sce_pkg::OP_J, sce_pkg::OP_LDLP, sce_pkg::OP_LDC, sce_pkg::OP_LDNLP,
                    sce_pkg::OP_AJW, sce_pkg::OP_EQC: q_item.cls = sce_pkg::CLS_ALU;
                    sce_pkg::OP_LDNL, sce_pkg::OP_LDL: q_item.cls = sce_pkg::CLS_LOAD;
                    sce_pkg::OP_STL, sce_pkg::OP_STNL: q_item.cls = sce_pkg::CLS_STORE;
                    sce_pkg::OP_OPR: begin
                        unique case (n)
                            sce_pkg::OPR_MOVE: q_item.cls = sce_pkg::CLS_MOVE;
                            sce_pkg::OPR_REV, sce_pkg::OPR_ADD, sce_pkg::OPR_SUB,
                            sce_pkg::OPR_STHF, sce_pkg::OPR_LDPI, sce_pkg::OPR_STLF,
                            sce_pkg::OPR_BCNT, sce_pkg::OPR_GAJW, sce_pkg::OPR_WCNT,
                            sce_pkg::OPR_MINT: q_item.cls = sce_pkg::CLS_ALU;
                            default: q_item.illegal = 1'b1;
                        endcase
                    end
                    default: q_item.illegal = 1'b1;
                endcase
            end
            sce_pkg::KIND_WRB: q_item.cls = sce_pkg::CLS_WRB;
            sce_pkg::KIND_RDB: q_item.cls = sce_pkg::CLS_RDB;
            sce_pkg::KIND_RESTART: begin
                q_item.cls   = sce_pkg::CLS_RESTART;
                operand_next = '0;
            end
            default: q_item.cls = sce_pkg::CLS_RESTART;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            operand_reg <= '0;
        end else if (q_push) begin
            operand_reg <= operand_next;
        end
    end
endmodule
`default_nettype wire

### src/sce_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on sce_pkg.
`default_nettype none
module sce_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  sce_pkg::item_t       item_in,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output sce_pkg::item_t       item_out
);
    sce_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = count_reg == 2'd2;
    assign valid    = count_reg != 2'd0;
    assign item_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### src/sce_back.sv
// Back end: executes items on the stack registers and byte memory, holds the result.
// Depends on sce_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sce_back #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                q_valid,
    input  sce_pkg::item_t                           q_item,
    output logic                                     q_pop,
    input  wire logic                                cfg_we,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [31:0]                         cfg_wdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [sce_pkg::OUT_TDATA_W-1:0]          m_tdata
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW:0]   SWEEP_END = (AW+1)'(MEM_BYTES);
    localparam logic [31:0]   MEM_SIZE  = 32'(MEM_BYTES);

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] snap [MEM_BYTES];

    logic            mem_we, snap_we;
    logic [AW-1:0]   mem_waddr, mem_raddr, snap_waddr, snap_raddr;
    logic [7:0]      mem_wdata, mem_rdata_reg, snap_rdata_reg;

    sce_pkg::state_t state_reg, state_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [31:0] pc_reg, pc_next, ws_reg, ws_next, fh_reg, fh_next, fl_reg, fl_next;
    logic        err_reg, err_next, illegal_reg, illegal_next, m_valid_reg, m_valid_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic [31:0] start_pc_reg, start_ws_reg;
    logic [31:0] word_reg, word_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic        ld_push_reg, ld_push_next;
    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [AW:0] sweep_reg, sweep_next;
    logic [AW-1:0] src_reg, src_next, dist_reg, dist_next, k_reg, k_next, j_reg, j_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;

    logic        out_free;
    logic [31:0] n, n4, base, sum, first, ma32;
    logic [AW:0] trial;
    logic [AW-1:0] move_dist;

    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, fl_reg, fh_reg, rbyte_reg, illegal_reg, err_reg,
                        ws_reg, pc_reg, c_reg, b_reg, a_reg};
    assign n         = q_item.operand;
    assign n4        = n << 2;
    assign ma32      = {20'b0, q_item.mem_addr};
    assign move_dist = b_reg[AW-1:0] - c_reg[AW-1:0];
    assign first     = a_reg - MEM_SIZE;
    assign trial     = {rem_reg, div_reg[31]};

    always_comb begin
        state_next    = state_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg;
        pc_next = pc_reg; ws_next = ws_reg; fh_next = fh_reg; fl_next = fl_reg;
        err_next      = err_reg;
        illegal_next  = illegal_reg;
        rbyte_next    = rbyte_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        word_next     = word_reg;
        addr_next     = addr_reg;
        ld_push_next  = ld_push_reg;
        byte_cnt_next = byte_cnt_reg;
        sweep_next    = sweep_reg;
        src_next = src_reg; dist_next = dist_reg; k_next = k_reg; j_next = j_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        div_cnt_next  = div_cnt_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = word_reg[7:0];
        mem_raddr     = addr_reg;
        snap_we       = 1'b0;
        snap_waddr    = sweep_reg[AW-1:0] - 1'b1;
        snap_raddr    = src_reg + j_reg;
        base          = '0;
        sum           = '0;
        unique case (state_reg)
            sce_pkg::ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop        = 1'b1;
                    illegal_next = q_item.illegal;
                    rbyte_next   = '0;
                    pc_next      = pc_reg + 32'd1;
                    unique case (q_item.cls)
                        sce_pkg::CLS_ALU: begin
                            m_valid_next = 1'b1;
                            if (!q_item.illegal) begin
                                unique case (q_item.opcode)
                                    sce_pkg::OP_J: pc_next = pc_reg + 32'd1 + n;
                                    sce_pkg::OP_LDLP: begin
                                        a_next = ws_reg + n4; b_next = a_reg; c_next = b_reg;
                                    end
                                    sce_pkg::OP_LDC: begin
                                        a_next = n; b_next = a_reg; c_next = b_reg;
                                    end
                                    sce_pkg::OP_LDNLP: a_next = a_reg + n4;
                                    sce_pkg::OP_AJW: ws_next = ws_reg + n4;
                                    sce_pkg::OP_EQC: a_next = {31'b0, a_reg == n};
                                    sce_pkg::OP_OPR: begin
                                        unique case (n)
                                            sce_pkg::OPR_REV: begin
                                                a_next = b_reg; b_next = a_reg;
                                            end
                                            sce_pkg::OPR_ADD: begin
                                                sum = b_reg + a_reg;
                                                if ((~(a_reg ^ b_reg) & (a_reg ^ sum)
                                                     & sce_pkg::MINT_VALUE) != '0) begin
                                                    err_next = 1'b1;
                                                end
                                                a_next = sum; b_next = c_reg;
                                            end
                                            sce_pkg::OPR_SUB: begin
                                                sum = b_reg - a_reg;
                                                if (((a_reg ^ b_reg) & (b_reg ^ sum)
                                                     & sce_pkg::MINT_VALUE) != '0) begin
                                                    err_next = 1'b1;
                                                end
                                                a_next = sum; b_next = c_reg;
                                            end
                                            sce_pkg::OPR_STHF: begin
                                                fh_next = a_reg; a_next = b_reg; b_next = c_reg;
                                            end
                                            sce_pkg::OPR_LDPI: a_next = a_reg + pc_reg + 32'd1;
                                            sce_pkg::OPR_STLF: begin
                                                fl_next = a_reg; a_next = b_reg; b_next = c_reg;
                                            end
                                            sce_pkg::OPR_BCNT: a_next = a_reg << 2;
                                            sce_pkg::OPR_GAJW: begin
                                                a_next  = ws_reg;
                                                ws_next = a_reg & sce_pkg::WORD_ALIGN;
                                            end
                                            sce_pkg::OPR_WCNT: begin
                                                c_next = b_reg;
                                                b_next = a_reg & sce_pkg::BYTE_SEL;
                                                a_next = a_reg >> 2;
                                            end
                                            sce_pkg::OPR_MINT: begin
                                                a_next = sce_pkg::MINT_VALUE;
                                                b_next = a_reg; c_next = b_reg;
                                            end
                                            default: a_next = a_reg;
                                        endcase
                                    end
                                    default: a_next = a_reg;
                                endcase
                            end
                        end
                        sce_pkg::CLS_LOAD: begin
                            base          = (q_item.opcode == sce_pkg::OP_LDNL ? a_reg : ws_reg)
                                            + n4;
                            addr_next     = base[AW-1:0];
                            ld_push_next  = q_item.opcode == sce_pkg::OP_LDL;
                            byte_cnt_next = '0;
                            state_next    = sce_pkg::ST_LOAD;
                        end
                        sce_pkg::CLS_STORE: begin
                            if (q_item.opcode == sce_pkg::OP_STL) begin
                                base = ws_reg + n4; word_next = a_reg;
                                a_next = b_reg; b_next = c_reg;
                            end else begin
                                base = a_reg + n4; word_next = b_reg;
                                a_next = c_reg;
                            end
                            addr_next     = base[AW-1:0];
                            byte_cnt_next = '0;
                            state_next    = sce_pkg::ST_STORE;
                        end
                        sce_pkg::CLS_MOVE: begin
                            if (move_dist == '0 || a_reg == '0) begin
                                m_valid_next = 1'b1;
                            end else begin
                                src_next   = c_reg[AW-1:0];
                                dist_next  = move_dist;
                                sweep_next = '0;
                                state_next = sce_pkg::ST_SNAP;
                            end
                        end
                        sce_pkg::CLS_WRB: begin
                            pc_next      = pc_reg;
                            mem_we       = 1'b1;
                            mem_waddr    = ma32[AW-1:0];
                            mem_wdata    = q_item.mem_byte;
                            m_valid_next = 1'b1;
                        end
                        sce_pkg::CLS_RDB: begin
                            pc_next    = pc_reg;
                            mem_raddr  = ma32[AW-1:0];
                            state_next = sce_pkg::ST_RDB;
                        end
                        sce_pkg::CLS_RESTART: begin
                            pc_next      = start_pc_reg;
                            ws_next      = start_ws_reg;
                            m_valid_next = 1'b1;
                        end
                        default: state_next = sce_pkg::ST_IDLE;
                    endcase
                end
            end
            sce_pkg::ST_LOAD: begin
                mem_raddr     = addr_reg + AW'(byte_cnt_reg[1:0]);
                byte_cnt_next = byte_cnt_reg + 3'd1;
                if (byte_cnt_reg != 3'd0) begin
                    word_next = {mem_rdata_reg, word_reg[31:8]};
                end
                if (byte_cnt_reg == 3'd4) begin
                    if (ld_push_reg) begin
                        a_next = word_next; b_next = a_reg; c_next = b_reg;
                    end else begin
                        a_next = word_next;
                    end
                    m_valid_next = 1'b1;
                    state_next   = sce_pkg::ST_IDLE;
                end
            end
            sce_pkg::ST_STORE: begin
                mem_we        = 1'b1;
                mem_waddr     = addr_reg + AW'(byte_cnt_reg[1:0]);
                word_next     = word_reg >> 8;
                byte_cnt_next = byte_cnt_reg + 3'd1;
                if (byte_cnt_reg == 3'd3) begin
                    m_valid_next = 1'b1;
                    state_next   = sce_pkg::ST_IDLE;
                end
            end
            sce_pkg::ST_RDB: begin
                rbyte_next   = mem_rdata_reg;
                m_valid_next = 1'b1;
                state_next   = sce_pkg::ST_IDLE;
            end
            sce_pkg::ST_SNAP: begin
                mem_raddr  = sweep_reg[AW-1:0];
                snap_we    = sweep_reg != '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == SWEEP_END) begin
                    snap_raddr = src_reg;
                    if (a_reg > MEM_SIZE) begin
                        div_next     = first;
                        rem_next     = '0;
                        div_cnt_next = '0;
                        k_next       = first[AW-1:0];
                        sweep_next   = SWEEP_END;
                        state_next   = sce_pkg::ST_DIV;
                    end else begin
                        k_next     = '0;
                        j_next     = '0;
                        sweep_next = a_reg[AW:0];
                        state_next = sce_pkg::ST_COPY_RD;
                    end
                end
            end
            sce_pkg::ST_DIV: begin
                if (trial >= {1'b0, dist_reg}) begin
                    rem_next = AW'(trial - {1'b0, dist_reg});
                end else begin
                    rem_next = trial[AW-1:0];
                end
                div_next     = div_reg << 1;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31) begin
                    j_next     = rem_next;
                    state_next = sce_pkg::ST_COPY_RD;
                end
            end
            sce_pkg::ST_COPY_RD: begin
                state_next = sce_pkg::ST_COPY_WR;
            end
            sce_pkg::ST_COPY_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = src_reg + dist_reg + k_reg;
                mem_wdata  = snap_rdata_reg;
                k_next     = k_reg + 1'b1;
                j_next     = (j_reg == dist_reg - 1'b1) ? '0 : j_reg + 1'b1;
                sweep_next = sweep_reg - 1'b1;
                if (sweep_reg == (AW+1)'(1)) begin
                    m_valid_next = 1'b1;
                    state_next   = sce_pkg::ST_IDLE;
                end else begin
                    state_next = sce_pkg::ST_COPY_RD;
                end
            end
            default: state_next = sce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (snap_we) begin
            snap[snap_waddr] <= mem_rdata_reg;
        end
        snap_rdata_reg <= snap[snap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= '0;
            start_ws_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == sce_pkg::CFG_START_PC) begin
                start_pc_reg <= cfg_wdata;
            end
            if (cfg_addr == sce_pkg::CFG_START_WS) begin
                start_ws_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sce_pkg::ST_IDLE;
            a_reg       <= '0;
            b_reg       <= '0;
            c_reg       <= '0;
            pc_reg      <= '0;
            ws_reg      <= '0;
            fh_reg      <= '0;
            fl_reg      <= '0;
            err_reg     <= 1'b0;
            illegal_reg <= 1'b0;
            rbyte_reg   <= '0;
            m_valid_reg <= 1'b0;
            byte_cnt_reg <= '0;
            sweep_reg   <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            c_reg       <= c_next;
            pc_reg      <= pc_next;
            ws_reg      <= ws_next;
            fh_reg      <= fh_next;
            fl_reg      <= fl_next;
            err_reg     <= err_next;
            illegal_reg <= illegal_next;
            rbyte_reg   <= rbyte_next;
            m_valid_reg <= m_valid_next;
            byte_cnt_reg <= byte_cnt_next;
            sweep_reg   <= sweep_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg    <= word_next;
        addr_reg    <= addr_next;
        ld_push_reg <= ld_push_next;
        src_reg     <= src_next;
        dist_reg    <= dist_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
    end

    `SCE_ASSERT_IMPL(a_busy_no_result, aclk, aresetn, state_reg != sce_pkg::ST_IDLE, !m_valid_reg)
    `SCE_ASSERT_IMPL(a_copy_in_range, aclk, aresetn, state_reg == sce_pkg::ST_COPY_WR, j_reg < dist_reg && sweep_reg != '0)
    `SCE_ASSERT_NEXT(a_store_ends, aclk, aresetn, state_reg == sce_pkg::ST_STORE && byte_cnt_reg == 3'd3, state_reg == sce_pkg::ST_IDLE && m_valid_reg)
endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking bench for the stack CPU instruction executor: drives instruction, memory and
// restart transfers, predicts results (or takes a typed row's) and compares field by field.
// Depends on sce_pkg and stack_cpu_instruction_executor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_SZ = 4096;
    localparam int LIMIT  = 3_000_000;

    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] fptr_back;
        logic [31:0] fptr_front;
        logic [7:0]  read_byte;
        logic        illegal;
        logic        overflow_flag;
        logic [31:0] workspace;
        logic [31:0] next_pc;
        logic [31:0] reg_c;
        logic [31:0] reg_b;
        logic [31:0] reg_a;
    } cpu_state_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  ib;
        logic [11:0] addr;
        logic [7:0]  wb;
        bit          typed;
        cpu_state_t  res;
    } stim_row_t;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0, cfg_we = 0;
    logic [sce_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic [sce_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_tready, m_tvalid;
    logic [sce_pkg::OUT_TDATA_W-1:0] m_tdata;

    stack_cpu_instruction_executor dut (.*);

    // predictor state
    logic [31:0] ra, rb, rc, oreg, pc_q, ws_q, fp_hi, fp_lo, boot_pc, boot_ws;
    logic        ovf;
    logic [7:0]  mem [MEM_SZ];
    logic [7:0]  snap [MEM_SZ];

    cpu_state_t  pending_q[$];
    stim_row_t   dir_tab[$];
    int snd_idle = 0, rcv_idle = 0, n_bad = 0, cycles = 0;

    initial forever #5 aclk = ~aclk;

    function automatic logic [31:0] load_word(logic [31:0] x);
        logic [31:0] w;
        logic [11:0] p;
        for (int k = 0; k < 4; k++) begin
            p = x[11:0] + 12'(k);
            w[8*k +: 8] = mem[p];
        end
        return w;
    endfunction

    function automatic void store_word(logic [31:0] x, logic [31:0] w);
        logic [11:0] p;
        for (int k = 0; k < 4; k++) begin
            p = x[11:0] + 12'(k);
            mem[p] = w[8*k +: 8];
        end
    endfunction

    function automatic void push_stack(logic [31:0] v);
        rc = rb;
        rb = ra;
        ra = v;
    endfunction

    function automatic void copy_bytes(logic [31:0] src, logic [31:0] dst, logic [31:0] cnt);
        logic [11:0] s, d, to, from;
        longint unsigned first;
        s = src[11:0];
        d = dst[11:0] - s;
        if (d == 0 || cnt == 0) return;
        snap = mem;
        first = (cnt > MEM_SZ) ? cnt - MEM_SZ : 0;
        for (longint unsigned i = first; i < cnt; i++) begin
            to = s + d + 12'(i % MEM_SZ);
            from = s + 12'(i % d);
            mem[to] = snap[from];
        end
    endfunction

    function automatic bit run_operate(logic [31:0] code);
        logic [31:0] a, b, r;
        a = ra;
        b = rb;
        case (code)
            sce_pkg::OPR_REV: begin ra = b; rb = a; end
            sce_pkg::OPR_ADD: begin
                r = b + a;
                if (a[31] == b[31] && r[31] != a[31]) ovf = 1;
                ra = r; rb = rc;
            end
            sce_pkg::OPR_SUB: begin
                r = b - a;
                if (a[31] != b[31] && r[31] != b[31]) ovf = 1;
                ra = r; rb = rc;
            end
            sce_pkg::OPR_STHF: begin fp_hi = a; ra = b; rb = rc; end
            sce_pkg::OPR_LDPI: ra = a + pc_q + 1;
            sce_pkg::OPR_STLF: begin fp_lo = a; ra = b; rb = rc; end
            sce_pkg::OPR_BCNT: ra = a << 2;
            sce_pkg::OPR_GAJW: begin ra = ws_q; ws_q = a & sce_pkg::WORD_ALIGN; end
            sce_pkg::OPR_WCNT: begin rc = b; rb = a & sce_pkg::BYTE_SEL; ra = a >> 2; end
            sce_pkg::OPR_MINT: push_stack(sce_pkg::MINT_VALUE);
            sce_pkg::OPR_MOVE: copy_bytes(rc, rb, a);
            default: return 0;
        endcase
        return 1;
    endfunction

    function automatic cpu_state_t step_cpu(logic [1:0] kind, logic [7:0] ib,
                                            logic [11:0] addr, logic [7:0] wb);
        cpu_state_t o;
        logic [31:0] n, nxt;
        bit ok;
        o = '0;
        case (kind)
            sce_pkg::KIND_EXEC: begin
                n = oreg | (ib & sce_pkg::NIB_MASK);
                nxt = pc_q + 1;
                ok = 1;
                case (ib[7:4])
                    sce_pkg::OP_J:     nxt = pc_q + 1 + n;
                    sce_pkg::OP_LDLP:  push_stack(ws_q + n * 4);
                    sce_pkg::OP_PFIX:  oreg = n << 4;
                    sce_pkg::OP_LDNL:  ra = load_word(ra + n * 4);
                    sce_pkg::OP_LDC:   push_stack(n);
                    sce_pkg::OP_LDNLP: ra = ra + n * 4;
                    sce_pkg::OP_NFIX:  oreg = (~n) << 4;
                    sce_pkg::OP_LDL:   push_stack(load_word(ws_q + n * 4));
                    sce_pkg::OP_AJW:   ws_q = ws_q + n * 4;
                    sce_pkg::OP_EQC:   ra = (ra == n) ? 32'd1 : 32'd0;
                    sce_pkg::OP_STL: begin
                        store_word(ws_q + n * 4, ra);
                        ra = rb; rb = rc;
                    end
                    sce_pkg::OP_STNL: begin
                        store_word(ra + n * 4, rb);
                        ra = rc;
                    end
                    sce_pkg::OP_OPR:   ok = run_operate(n);
                    default:           ok = 0;
                endcase
                if (ib[7:4] != sce_pkg::OP_PFIX && ib[7:4] != sce_pkg::OP_NFIX) oreg = 0;
                pc_q = nxt;
                o.illegal = !ok;
            end
            sce_pkg::KIND_WRB: mem[addr] = wb;
            sce_pkg::KIND_RDB: o.read_byte = mem[addr];
            default: begin
                pc_q = boot_pc;
                ws_q = boot_ws;
                oreg = 0;
            end
        endcase
        o.reg_a = ra; o.reg_b = rb; o.reg_c = rc;
        o.next_pc = pc_q; o.workspace = ws_q;
        o.overflow_flag = ovf;
        o.fptr_front = fp_hi; o.fptr_back = fp_lo;
        return o;
    endfunction

    task automatic send(logic [1:0] kind, logic [7:0] ib, logic [11:0] addr, logic [7:0] wb,
                        bit typed = 0, cpu_state_t res = '0);
        cpu_state_t p;
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {4'b0, wb, addr, ib};
        do @(posedge aclk); while (!s_tready);
        p = step_cpu(kind, ib, addr, wb);
        pending_q.push_back(typed ? res : p);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_boot(logic [31:0] pc_v, logic [31:0] ws_v);
        cfg_we <= 1;
        cfg_addr <= sce_pkg::CFG_START_PC;
        cfg_wdata <= pc_v;
        @(posedge aclk);
        cfg_addr <= sce_pkg::CFG_START_WS;
        cfg_wdata <= ws_v;
        @(posedge aclk);
        cfg_we <= 0;
        boot_pc = pc_v;
        boot_ws = ws_v;
    endtask

    task automatic send_exec(logic [7:0] ib);
        send(sce_pkg::KIND_EXEC, ib, 12'($urandom), 8'($urandom));
    endtask

    task automatic send_opr(logic [31:0] code);
        if (code > sce_pkg::NIB_MASK) send_exec({sce_pkg::OP_PFIX, code[7:4]});
        send_exec({sce_pkg::OP_OPR, code[3:0]});
    endtask

    task automatic random_part(int count);
        logic [31:0] codes[10];
        int r;
        codes = '{sce_pkg::OPR_REV, sce_pkg::OPR_ADD, sce_pkg::OPR_SUB, sce_pkg::OPR_STHF,
                  sce_pkg::OPR_LDPI, sce_pkg::OPR_STLF, sce_pkg::OPR_BCNT,
                  sce_pkg::OPR_GAJW, sce_pkg::OPR_WCNT, sce_pkg::OPR_MINT};
        for (int it = 0; it < count; it++) begin
            r = $urandom_range(99);
            if (it == count / 2) wait_idle();
            if (r < 8) send(sce_pkg::KIND_WRB, 8'($urandom), 12'($urandom), 8'($urandom));
            else if (r < 14)
                send(sce_pkg::KIND_RDB, 8'($urandom), 12'($urandom), 8'($urandom));
            else if (r < 16)
                send(sce_pkg::KIND_RESTART, 8'($urandom), 12'($urandom), 8'($urandom));
            else if (r < 55) send_exec(8'($urandom));
            else if (r < 80) send_opr(codes[$urandom_range(9)]);
            else if (r < 88) begin
                send_exec({sce_pkg::OP_NFIX, 4'($urandom)});
                send_exec({sce_pkg::OP_LDC, 4'($urandom)});
            end else if (r < 93) begin
                repeat (3) send_exec({sce_pkg::OP_LDC, 4'($urandom)});
                send_opr(sce_pkg::OPR_MOVE);
            end else begin
                send_exec({sce_pkg::OP_LDC, 4'($urandom)});
                send_exec({($urandom_range(1) ? sce_pkg::OP_STNL : sce_pkg::OP_LDNL),
                           4'($urandom)});
                send_exec({($urandom_range(1) ? sce_pkg::OP_STL : sce_pkg::OP_LDL),
                           4'($urandom)});
            end
        end
    endtask

    function automatic void add_row(logic [1:0] kind, logic [7:0] ib, logic [11:0] addr = 0,
                                    logic [7:0] wb = 0, bit typed = 0, cpu_state_t res = '0);
        stim_row_t t;
        t.kind = kind; t.ib = ib; t.addr = addr; t.wb = wb; t.typed = typed; t.res = res;
        dir_tab.push_back(t);
    endfunction

    function automatic cpu_state_t known(logic [31:0] a, logic [31:0] pc, logic ill);
        cpu_state_t o;
        o = '0;
        o.reg_a = a; o.next_pc = pc; o.illegal = ill;
        return o;
    endfunction

    always @(posedge aclk) begin
        cpu_state_t got, want;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
            if (m_tvalid && m_tready) begin
                got = cpu_state_t'(m_tdata);
                if (pending_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected result transfer %h", m_tdata);
                end else begin
                    want = pending_q.pop_front();
                    if (got.reg_a !== want.reg_a || got.reg_b !== want.reg_b ||
                        got.reg_c !== want.reg_c || got.next_pc !== want.next_pc ||
                        got.workspace !== want.workspace ||
                        got.overflow_flag !== want.overflow_flag ||
                        got.illegal !== want.illegal || got.read_byte !== want.read_byte ||
                        got.fptr_front !== want.fptr_front ||
                        got.fptr_back !== want.fptr_back) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("result mismatch: exp %h got %h", want, got);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("stack_cpu_instruction_executor: mismatch");
            $finish;
        end
    end

    initial begin
        ra = 0; rb = 0; rc = 0; oreg = 0; pc_q = 0; ws_q = 0; fp_hi = 0; fp_lo = 0; ovf = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        set_boot(32'($urandom), 32'($urandom));

        add_row(sce_pkg::KIND_EXEC, {sce_pkg::OP_LDC, 4'hF}, 0, 0, 1, known(32'hF, 1, 0));
        add_row(sce_pkg::KIND_EXEC, 8'h80, 0, 0, 1, known(32'hF, 2, 1));
        add_row(sce_pkg::KIND_EXEC, 8'h90, 0, 0, 1, known(32'hF, 3, 1));
        add_row(sce_pkg::KIND_EXEC, {sce_pkg::OP_OPR, 4'h1}, 0, 0, 1, known(32'hF, 4, 1));

        // seed 64 bytes, then a move of 4032 bytes replicates them over the rest of memory
        for (int i = 0; i < 64; i++)
            add_row(sce_pkg::KIND_WRB, 8'h00, 12'(i), 8'($urandom));
        add_row(sce_pkg::KIND_EXEC, 8'h40);
        add_row(sce_pkg::KIND_EXEC, 8'h24); add_row(sce_pkg::KIND_EXEC, 8'h40);
        add_row(sce_pkg::KIND_EXEC, 8'h2F); add_row(sce_pkg::KIND_EXEC, 8'h2C);
        add_row(sce_pkg::KIND_EXEC, 8'h40);
        add_row(sce_pkg::KIND_EXEC, 8'h24); add_row(sce_pkg::KIND_EXEC, 8'hFA);

        add_row(sce_pkg::KIND_EXEC, 8'h24); add_row(sce_pkg::KIND_EXEC, 8'hF2);
        add_row(sce_pkg::KIND_EXEC, 8'h24); add_row(sce_pkg::KIND_EXEC, 8'hF2);
        add_row(sce_pkg::KIND_EXEC, {sce_pkg::OP_OPR, sce_pkg::OPR_ADD[3:0]});
        add_row(sce_pkg::KIND_EXEC, 8'h60); add_row(sce_pkg::KIND_EXEC, 8'h4F);
        add_row(sce_pkg::KIND_EXEC, {sce_pkg::OP_OPR, sce_pkg::OPR_SUB[3:0]});
        add_row(sce_pkg::KIND_EXEC, {sce_pkg::OP_OPR, sce_pkg::OPR_REV[3:0]});
        add_row(sce_pkg::KIND_EXEC, 8'h21); add_row(sce_pkg::KIND_EXEC, 8'hFB);
        add_row(sce_pkg::KIND_EXEC, 8'h21); add_row(sce_pkg::KIND_EXEC, 8'hF8);
        add_row(sce_pkg::KIND_EXEC, 8'h21); add_row(sce_pkg::KIND_EXEC, 8'hFC);
        add_row(sce_pkg::KIND_EXEC, 8'h23); add_row(sce_pkg::KIND_EXEC, 8'hF4);
        add_row(sce_pkg::KIND_EXEC, 8'h23); add_row(sce_pkg::KIND_EXEC, 8'hFF);
        add_row(sce_pkg::KIND_EXEC, 8'h23); add_row(sce_pkg::KIND_EXEC, 8'hFC);
        add_row(sce_pkg::KIND_EXEC, {sce_pkg::OP_J, 4'h0});
        add_row(sce_pkg::KIND_EXEC, 8'h1F); add_row(sce_pkg::KIND_EXEC, 8'h3F);
        add_row(sce_pkg::KIND_EXEC, 8'h5F);
        add_row(sce_pkg::KIND_EXEC, 8'hBF); add_row(sce_pkg::KIND_EXEC, 8'hC0);
        add_row(sce_pkg::KIND_EXEC, 8'hDF);
        add_row(sce_pkg::KIND_EXEC, 8'h7F); add_row(sce_pkg::KIND_EXEC, 8'hE1);
        add_row(sce_pkg::KIND_EXEC, 8'h4F); add_row(sce_pkg::KIND_EXEC, 8'h48);
        add_row(sce_pkg::KIND_EXEC, 8'h43);
        add_row(sce_pkg::KIND_EXEC, 8'h24); add_row(sce_pkg::KIND_EXEC, 8'hFA);
        add_row(sce_pkg::KIND_WRB, 8'h00, 12'hFFF, 8'hFF);
        add_row(sce_pkg::KIND_RDB, 8'h00, 12'hFFF);
        add_row(sce_pkg::KIND_RESTART, 8'h00);

        snd_idle = 34;
        rcv_idle = 87;
        foreach (dir_tab[i])
            send(dir_tab[i].kind, dir_tab[i].ib, dir_tab[i].addr, dir_tab[i].wb,
                 dir_tab[i].typed, dir_tab[i].res);
        random_part(180);

        wait_idle();
        set_boot(32'hFFFF_FFFF, 32'h0);
        snd_idle = 87;
        rcv_idle = 34;
        random_part(200);

        wait_idle();
        set_boot(32'h0, 32'hFFFF_FFFF);
        snd_idle = 0;
        rcv_idle = 0;
        random_part(200);

        wait_idle();
        repeat (50) @(posedge aclk);
        if (n_bad == 0 && pending_q.size() == 0)
            $display("stack_cpu_instruction_executor: match");
        else
            $display("stack_cpu_instruction_executor: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
